/* rtl/spectrum_peak_hold_tracker_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum peak hold tracker
// Same-cycle and next-cycle implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_PEAK_HOLD_TRACKER_ASSERT_SVH
`define SPECTRUM_PEAK_HOLD_TRACKER_ASSERT_SVH

// cons must hold in the cycle where ante holds
`define SPHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spht assertion failed");

// cons must hold in the cycle after ante holds
`define SPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spht assertion failed");

`endif

/* rtl/spht_pkg.sv */
// ----------------------------------------------------------------------------
// spht_pkg
// Shared types and constants of the spectrum peak hold tracker.
// ----------------------------------------------------------------------------
package spht_pkg;

  localparam int unsigned CHANNELS_DEF = 128;
  localparam int unsigned SAMPLES_DEF  = 50;
  localparam int unsigned BAR_MAX_DEF  = 31;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned CH_W      = 7;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned HGT_W     = 5;
  localparam int unsigned DENS_W    = 2;
  localparam int unsigned PCT_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [VAL_W-1:0] HOLD_FRAMES_RST  = 8'd30;
  localparam logic [VAL_W-1:0] FAINT_LEVEL_RST  = 8'd5;
  localparam logic [VAL_W-1:0] STRONG_LEVEL_RST = 8'd20;

  localparam logic [VAL_W-1:0] PCT_SCALE = 8'd100;

  // Division by SAMPLES: numerators stay below 2^NUM_W, reciprocal scaled by 2^RECIP_SHIFT
  localparam int unsigned NUM_W       = 16;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  localparam logic [PCT_W-1:0] PCT_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_EOF    = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_FRAMES  = 2'd0,
    CFG_FAINT_LEVEL  = 2'd1,
    CFG_STRONG_LEVEL = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_REPLY   = 1'b1
  } kind_e;

  typedef enum logic [DENS_W-1:0] {
    DENS_NONE   = 2'd0,
    DENS_FAINT  = 2'd1,
    DENS_STRONG = 2'd2
  } density_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SWEEP,
    ST_LOAD,
    ST_MUL,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic [VAL_W-1:0] hold_frames;
    logic [VAL_W-1:0] faint_level;
    logic [VAL_W-1:0] strong_level;
  } cfg_t;

  typedef struct packed {
    opcode_e         op;
    logic            in_range;
    logic [CH_W-1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_in_t;

  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] count;
    logic [VAL_W-1:0] frame;
    logic [VAL_W-1:0] peak;
    logic [VAL_W-1:0] timer;
  } entry_t;

  typedef struct packed {
    kind_e            kind;
    logic [CH_W-1:0]  chan_out;
    logic [VAL_W-1:0] level;
    logic [VAL_W-1:0] held_peak;
    logic [HGT_W-1:0] bar_height;
    logic [HGT_W-1:0] dot_height;
    density_e         density;
    logic [PCT_W-1:0] percent;
  } result_t;

endpackage

/* rtl/spht_chan_if.sv */
// ----------------------------------------------------------------------------
// spht_in_if / spht_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface spht_in_if;
  logic                          valid;
  logic                          ready;
  logic [spht_pkg::OPCODE_W-1:0] opcode;
  logic [spht_pkg::CH_W-1:0]     channel;
  logic                          hit;

  modport source (output valid, opcode, channel, hit, input ready);
  modport sink   (input valid, opcode, channel, hit, output ready);
endinterface

interface spht_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [spht_pkg::CH_W-1:0]  chan_out;
  logic [spht_pkg::VAL_W-1:0] level;
  logic [spht_pkg::VAL_W-1:0] held_peak;
  logic [spht_pkg::HGT_W-1:0] bar_height;
  logic [spht_pkg::HGT_W-1:0] dot_height;
  logic [spht_pkg::DENS_W-1:0] density;
  logic [spht_pkg::PCT_W-1:0] percent;

  modport source (output valid, kind, chan_out, level, held_peak, bar_height, dot_height,
                  density, percent, input ready);
  modport sink   (input valid, kind, chan_out, level, held_peak, bar_height, dot_height,
                  density, percent, output ready);
endinterface

/* rtl/spht_front.sv */
// ----------------------------------------------------------------------------
// spht_front
// Accepts input items and turns the ones that do work into queue commands.
// ----------------------------------------------------------------------------
module spht_front #(
  parameter int unsigned CHANNELS = spht_pkg::CHANNELS_DEF
) (
  spht_in_if.sink         in_i,
  input  logic            q_full_i,
  output spht_pkg::q_in_t q_in_o
);

  logic in_range;
  logic keep;

  assign in_i.ready = !q_full_i;
  assign in_range   = 32'(in_i.channel) < CHANNELS;

  always_comb begin
    case (in_i.opcode)
      spht_pkg::OP_SAMPLE: keep = in_i.hit && in_range;
      spht_pkg::OP_EOF:    keep = 1'b1;
      spht_pkg::OP_READ:   keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  // drop idle and out-of-range samples and unknown opcodes here, the transfer still completes
  always_comb begin
    q_in_o.push         = in_i.valid && in_i.ready && keep;
    q_in_o.cmd.op       = spht_pkg::opcode_e'(in_i.opcode);
    q_in_o.cmd.in_range = in_range;
    q_in_o.cmd.chan     = in_i.channel;
  end

endmodule

/* rtl/spht_queue.sv */
// ----------------------------------------------------------------------------
// spht_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module spht_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spht_pkg::q_in_t  q_in_i,
  input  logic             pop_i,
  output logic             full_o,
  output spht_pkg::q_out_t q_out_o
);

  localparam int unsigned DEPTH = spht_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  spht_pkg::cmd_t   slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign full_o = cnt_q == (PTR_W + 1)'(DEPTH);
  assign push   = q_in_i.push && !full_o;
  assign pop    = pop_i && (cnt_q != '0);

  assign q_out_o.avail = cnt_q != '0;
  assign q_out_o.cmd   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= q_in_i.cmd;
    end
  end

endmodule

/* rtl/spht_back.sv */
// ----------------------------------------------------------------------------
// spht_back
// Executes commands against the per-channel table and builds the results.
// ----------------------------------------------------------------------------
module spht_back #(
  parameter int unsigned CHANNELS = spht_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLES  = spht_pkg::SAMPLES_DEF,
  parameter int unsigned BAR_MAX  = spht_pkg::BAR_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spht_pkg::cfg_t   cfg_i,
  input  spht_pkg::q_out_t q_out_i,
  output logic             pop_o,
  spht_out_if.source       out_o
);

  localparam int unsigned AW = $clog2(CHANNELS);
  localparam longint unsigned RECIP =
    ((64'd1 << spht_pkg::RECIP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [spht_pkg::RECIP_W-1:0] RECIP_V = spht_pkg::RECIP_W'(RECIP);
  localparam int unsigned HMAX = (BAR_MAX < 31) ? BAR_MAX : 31;
  localparam logic [spht_pkg::NUM_W-1:0] HMAX_N = spht_pkg::NUM_W'(HMAX);
  localparam logic [spht_pkg::VAL_W-1:0] BAR_MAX_V = spht_pkg::VAL_W'(BAR_MAX);

  // channel table, one valid bit per entry stands in for the reset value
  spht_pkg::entry_t mem_q [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  spht_pkg::entry_t rd_data_q;
  logic             rd_vld_q;
  spht_pkg::entry_t rd_entry;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  spht_pkg::entry_t wr_data;

  spht_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]                  idx_q;
  logic [spht_pkg::CH_W-1:0]      chan_q;
  logic                           in_range_q;
  spht_pkg::kind_e                kind_q;
  logic [spht_pkg::VAL_W-1:0]     best_val_q;
  logic [AW-1:0]                  best_ch_q;
  logic [spht_pkg::VAL_W-1:0]     lvl_q;
  logic [spht_pkg::VAL_W-1:0]     peak_q;
  logic [spht_pkg::NUM_W-1:0]     num_a_q, num_b_q;
  logic [spht_pkg::PROD_W-1:0]    prod_a_q, prod_b_q;

  spht_pkg::result_t out_q, result_d;
  logic              out_valid_q;
  logic              out_free;
  logic              load_out;
  logic              sweep_last;

  spht_pkg::entry_t sample_entry;
  spht_pkg::entry_t sweep_entry;

  assign rd_entry   = rd_vld_q ? rd_data_q : '0;
  assign out_free   = !out_valid_q || out_o.ready;
  assign sweep_last = idx_q == AW'(CHANNELS - 1);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      spht_pkg::ST_IDLE: begin
        if (q_out_i.avail) begin
          case (q_out_i.cmd.op)
            spht_pkg::OP_SAMPLE: state_d = spht_pkg::ST_SAMPLE;
            spht_pkg::OP_EOF:    state_d = spht_pkg::ST_SWEEP;
            spht_pkg::OP_READ:   state_d = spht_pkg::ST_LOAD;
            default:             state_d = spht_pkg::ST_IDLE;
          endcase
        end
      end
      spht_pkg::ST_SAMPLE: state_d = spht_pkg::ST_IDLE;
      spht_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_d = spht_pkg::ST_LOAD;
        end
      end
      spht_pkg::ST_LOAD: state_d = spht_pkg::ST_MUL;
      spht_pkg::ST_MUL:  state_d = spht_pkg::ST_OUT;
      spht_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = spht_pkg::ST_IDLE;
        end
      end
      default: state_d = spht_pkg::ST_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = sweep_entry;
    load_out = 1'b0;
    case (state_q)
      spht_pkg::ST_IDLE: begin
        pop_o   = q_out_i.avail;
        rd_en   = q_out_i.avail &&
                  (q_out_i.cmd.op != spht_pkg::OP_READ || q_out_i.cmd.in_range);
        rd_addr = (q_out_i.cmd.op == spht_pkg::OP_EOF) ? '0 : q_out_i.cmd.chan[AW-1:0];
      end
      spht_pkg::ST_SAMPLE: begin
        wr_en   = 1'b1;
        wr_data = sample_entry;
      end
      spht_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        rd_en   = !sweep_last;
        rd_addr = idx_q + 1'b1;
      end
      spht_pkg::ST_OUT: load_out = out_free;
      default: ;
    endcase
  end

  // ---------------- entry updates ----------------
  always_comb begin
    sample_entry       = rd_entry;
    sample_entry.count = (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 1'b1;

    sweep_entry.count = '0;
    sweep_entry.frame = rd_entry.count;
    if (rd_entry.count >= rd_entry.peak) begin
      sweep_entry.peak  = rd_entry.count;
      sweep_entry.timer = cfg_i.hold_frames;
    end else if (rd_entry.timer != '0) begin
      sweep_entry.peak  = rd_entry.peak;
      sweep_entry.timer = rd_entry.timer - 1'b1;
    end else begin
      // hold expired: decay one step per frame
      sweep_entry.peak  = (rd_entry.peak != '0) ? rd_entry.peak - 1'b1 : rd_entry.peak;
      sweep_entry.timer = rd_entry.timer;
    end
  end

  // ---------------- result assembly ----------------
  always_comb begin
    logic [spht_pkg::NUM_W-1:0] quot_a;
    logic [spht_pkg::NUM_W-1:0] quot_b;
    quot_a = prod_a_q[spht_pkg::RECIP_SHIFT +: spht_pkg::NUM_W];
    quot_b = prod_b_q[spht_pkg::RECIP_SHIFT +: spht_pkg::NUM_W];

    result_d.kind       = kind_q;
    result_d.chan_out   = chan_q;
    result_d.level      = lvl_q;
    result_d.held_peak  = '0;
    result_d.bar_height = '0;
    result_d.dot_height = '0;
    result_d.density    = spht_pkg::DENS_NONE;
    result_d.percent    = '0;
    if (kind_q == spht_pkg::KIND_SUMMARY) begin
      result_d.percent = (quot_a > spht_pkg::NUM_W'(spht_pkg::PCT_MAX)) ?
                         spht_pkg::PCT_MAX : quot_a[spht_pkg::PCT_W-1:0];
    end else begin
      result_d.held_peak  = peak_q;
      result_d.bar_height = (quot_a > HMAX_N) ? HMAX_N[spht_pkg::HGT_W-1:0]
                                              : quot_a[spht_pkg::HGT_W-1:0];
      result_d.dot_height = (quot_b > HMAX_N) ? HMAX_N[spht_pkg::HGT_W-1:0]
                                              : quot_b[spht_pkg::HGT_W-1:0];
      if (lvl_q > cfg_i.strong_level) begin
        result_d.density = spht_pkg::DENS_STRONG;
      end else if (lvl_q > cfg_i.faint_level) begin
        result_d.density = spht_pkg::DENS_FAINT;
      end
    end
  end

  // ---------------- table memory ----------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spht_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      spht_pkg::ST_IDLE: begin
        if (q_out_i.avail) begin
          idx_q      <= (q_out_i.cmd.op == spht_pkg::OP_EOF) ? '0 : q_out_i.cmd.chan[AW-1:0];
          chan_q     <= q_out_i.cmd.chan;
          in_range_q <= q_out_i.cmd.in_range;
          kind_q     <= (q_out_i.cmd.op == spht_pkg::OP_READ) ? spht_pkg::KIND_REPLY
                                                              : spht_pkg::KIND_SUMMARY;
          best_val_q <= '0;
          best_ch_q  <= '0;
        end
      end
      spht_pkg::ST_SWEEP: begin
        idx_q <= idx_q + 1'b1;
        // strict compare keeps the lowest channel on ties
        if (rd_entry.count > best_val_q) begin
          best_val_q <= rd_entry.count;
          best_ch_q  <= idx_q;
        end
      end
      spht_pkg::ST_LOAD: begin
        if (kind_q == spht_pkg::KIND_REPLY) begin
          lvl_q   <= in_range_q ? rd_entry.frame : '0;
          peak_q  <= in_range_q ? rd_entry.peak : '0;
          num_a_q <= in_range_q ? spht_pkg::NUM_W'(rd_entry.frame) *
                                  spht_pkg::NUM_W'(BAR_MAX_V) : '0;
          num_b_q <= in_range_q ? spht_pkg::NUM_W'(rd_entry.peak) *
                                  spht_pkg::NUM_W'(BAR_MAX_V) : '0;
        end else begin
          chan_q  <= spht_pkg::CH_W'(best_ch_q);
          lvl_q   <= best_val_q;
          peak_q  <= '0;
          num_a_q <= spht_pkg::NUM_W'(best_val_q) * spht_pkg::NUM_W'(spht_pkg::PCT_SCALE);
          num_b_q <= '0;
        end
      end
      spht_pkg::ST_MUL: begin
        prod_a_q <= spht_pkg::PROD_W'(num_a_q) * spht_pkg::PROD_W'(RECIP_V);
        prod_b_q <= spht_pkg::PROD_W'(num_b_q) * spht_pkg::PROD_W'(RECIP_V);
      end
      default: ;
    endcase
    if (load_out) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.chan_out   = out_q.chan_out;
  assign out_o.level      = out_q.level;
  assign out_o.held_peak  = out_q.held_peak;
  assign out_o.bar_height = out_q.bar_height;
  assign out_o.dot_height = out_q.dot_height;
  assign out_o.density    = out_q.density;
  assign out_o.percent    = out_q.percent;

endmodule

/* rtl/spectrum_peak_hold_tracker.sv */
// ----------------------------------------------------------------------------
// spectrum_peak_hold_tracker
// Per-channel activity counter with peak hold, frame summary and readout.
// ----------------------------------------------------------------------------
// Items enter on in_i (opcode, channel, hit) and results leave on out_o;
// both are valid/ready channels, a transfer happens when valid and ready
// are high at a clock edge. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while the
// block is idle, the block does not enforce it. A two-entry command
// queue behind the input keeps in_i ready while the engine works, until
// it fills; idle and out-of-range samples and unknown opcodes are dropped
// in front of it. The engine handles one command at a time against a
// table with one read and one write port:
//   sample hit      read, write back
//   channel read    read, load, multiply, output
//   end of frame    sweep (one entry per cycle), load, multiply, output
// Divisions by SAMPLES use a reciprocal multiply in one registered stage.
// Reset clears the table through per-entry valid bits, so items are taken
// right after reset. When out_o stalls, the result holds in the output
// register; the engine waits, the queue fills and then in_i drops ready.
module spectrum_peak_hold_tracker #(
  parameter int unsigned CHANNELS = spht_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLES  = spht_pkg::SAMPLES_DEF,
  parameter int unsigned BAR_MAX  = spht_pkg::BAR_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spht_in_if.sink                        in_i,
  spht_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [spht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spht_pkg::VAL_W-1:0]     cfg_data_i
);

  spht_pkg::cfg_t   cfg_q;
  spht_pkg::q_in_t  q_in;
  spht_pkg::q_out_t q_out;
  logic             q_full;
  logic             q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_frames  <= spht_pkg::HOLD_FRAMES_RST;
      cfg_q.faint_level  <= spht_pkg::FAINT_LEVEL_RST;
      cfg_q.strong_level <= spht_pkg::STRONG_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spht_pkg::CFG_HOLD_FRAMES:  cfg_q.hold_frames  <= cfg_data_i;
        spht_pkg::CFG_FAINT_LEVEL:  cfg_q.faint_level  <= cfg_data_i;
        spht_pkg::CFG_STRONG_LEVEL: cfg_q.strong_level <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spht_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_in_o   (q_in)
  );

  spht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_in_i  (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .q_out_o (q_out)
  );

  spht_back #(
    .CHANNELS (CHANNELS),
    .SAMPLES  (SAMPLES),
    .BAR_MAX  (BAR_MAX)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .q_out_i (q_out),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/spht_checker.sv */
// ----------------------------------------------------------------------------
// spht_checker
// Port-level checks on the result channel of the tracker.
// ----------------------------------------------------------------------------
`include "spectrum_peak_hold_tracker_assert.svh"

module spht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_kind_i,
  input logic [spht_pkg::VAL_W-1:0]  out_level_i,
  input logic [spht_pkg::VAL_W-1:0]  out_held_peak_i,
  input logic [spht_pkg::HGT_W-1:0]  out_bar_height_i,
  input logic [spht_pkg::HGT_W-1:0]  out_dot_height_i,
  input logic [spht_pkg::DENS_W-1:0] out_density_i,
  input logic [spht_pkg::PCT_W-1:0]  out_percent_i
);

  logic is_summary;
  logic is_reply;

  assign is_summary = out_valid_i && (out_kind_i == spht_pkg::KIND_SUMMARY);
  assign is_reply   = out_valid_i && (out_kind_i == spht_pkg::KIND_REPLY);

  `SPHT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SPHT_ASSERT_SAME(a_summary_clean, clk_i, rst_ni, is_summary, out_held_peak_i == '0 && out_bar_height_i == '0 && out_dot_height_i == '0 && out_density_i == spht_pkg::DENS_NONE)
  `SPHT_ASSERT_SAME(a_reply_no_pct, clk_i, rst_ni, is_reply, out_percent_i == '0)
  `SPHT_ASSERT_SAME(a_reply_density, clk_i, rst_ni, is_reply && out_density_i != spht_pkg::DENS_NONE, out_level_i != '0 && (out_density_i == spht_pkg::DENS_FAINT || out_density_i == spht_pkg::DENS_STRONG))

endmodule

bind spectrum_peak_hold_tracker spht_checker u_spht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_level_i      (out_o.level),
  .out_held_peak_i  (out_o.held_peak),
  .out_bar_height_i (out_o.bar_height),
  .out_dot_height_i (out_o.dot_height),
  .out_density_i    (out_o.density),
  .out_percent_i    (out_o.percent)
);
